// ===== hw/rtl/iva_pkg.sv =====
package iva_pkg;

    // request modes
    localparam logic [1:0] MODE_REGISTER = 2'd0;
    localparam logic [1:0] MODE_RANGE    = 2'd1;
    localparam logic [1:0] MODE_CLEAR    = 2'd2;
    localparam logic [1:0] MODE_QUERY    = 2'd3;

    // configuration register indexes
    localparam logic [7:0] CFG_CODE_SELECTOR = 8'd0;
    localparam logic [7:0] CFG_FIRST_FREE    = 8'd1;

    // configuration reset values
    localparam logic [15:0] CODE_SELECTOR_RESET = 16'h0008;
    localparam logic [7:0]  FIRST_FREE_RESET    = 8'd32;

    // gate types and privilege levels
    localparam logic [3:0] GATE_INTERRUPT = 4'hE;
    localparam logic [3:0] GATE_TRAP      = 4'hF;
    localparam logic [1:0] DPL_USER       = 2'd3;
    localparam logic [1:0] DPL_KERNEL     = 2'd0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  vector;
        logic [63:0] handler_address;
        logic        reentrant;
        logic        user_level;
        logic [7:0]  range_count;
        logic [7:0]  shortest_run;
        logic        aligned;
    } iva_req_t;

    typedef struct packed {
        logic        status;
        logic [63:0] descriptor_low;
        logic [31:0] descriptor_high;
        logic [7:0]  range_start;
        logic [7:0]  range_len;
        logic        vector_used;
    } iva_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic step;
        logic commit;
    } iva_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic finish;
        logic out_free;
    } iva_stat_t;

endpackage

// ===== hw/rtl/iva_ctrl.sv =====
module iva_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  iva_pkg::iva_stat_t stat,
    output iva_pkg::iva_cmd_t  cmd
);
    import iva_pkg::*;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_WORK
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                // clearing pass after reset, no response
                if (stat.finish) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_WORK;
                end
            end
            ST_WORK: begin
                if (stat.finish) begin
                    // hold the finished result until the output slot frees
                    if (stat.out_free) begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/iva_datapath.sv =====
module iva_datapath #(
    parameter int VECTOR_COUNT = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  iva_pkg::iva_req_t  s_req,
    input  logic               cfg_valid,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  iva_pkg::iva_cmd_t  cmd,
    output iva_pkg::iva_stat_t stat,
    input  logic               m_ready,
    output logic               m_valid,
    output iva_pkg::iva_rsp_t  m_rsp
);
    import iva_pkg::*;

    localparam int IW   = $clog2(VECTOR_COUNT);
    localparam int SW   = $clog2(VECTOR_COUNT + 1);
    localparam int STW  = (SW > 8) ? SW : 8;
    localparam int SUMW = STW + 1;

    logic                    map_mem [VECTOR_COUNT];
    logic                    map_rd_reg;
    logic [15:0]             sel_reg;
    logic [7:0]              ffv_reg;
    iva_req_t                req_reg;
    logic [STW-1:0]          start_reg, start_next;
    logic [STW-1:0]          pos_reg, pos_next;
    logic [7:0]              run_reg, run_next;
    logic                    out_valid_reg;
    iva_rsp_t                out_reg;
    iva_rsp_t                rsp_next;

    logic [7:0]      need;
    logic [SUMW-1:0] win_end;
    logic            no_fit, whole, partial, bit_here, wiped;
    logic            vec_ok, vec_bit, refused;
    logic            map_we, map_wdata;
    logic [3:0]      gate_type;
    logic [1:0]      dpl;

    // range search terms
    always_comb begin
        need     = (req_reg.shortest_run == 8'd0) ? 8'd1 : req_reg.shortest_run;
        win_end  = SUMW'(start_reg) + SUMW'(req_reg.range_count);
        no_fit   = (req_reg.range_count == 8'd0) || (win_end > SUMW'(VECTOR_COUNT));
        bit_here = map_rd_reg;
        whole    = (run_reg == req_reg.range_count);
        partial  = bit_here && (run_reg >= need);
        wiped    = (pos_reg == STW'(VECTOR_COUNT));
    end

    // single vector terms; the read port sits on the vector for these modes
    always_comb begin
        vec_ok    = {1'b0, req_reg.vector} < 9'(VECTOR_COUNT);
        vec_bit   = map_rd_reg;
        refused   = !vec_ok || vec_bit;
        gate_type = req_reg.reentrant ? GATE_TRAP : GATE_INTERRUPT;
        dpl       = req_reg.user_level ? DPL_USER : DPL_KERNEL;
    end

    assign stat.finish   = (req_reg.mode == MODE_RANGE) ? (no_fit || whole || partial) :
                           (req_reg.mode == MODE_CLEAR) ? wiped : 1'b1;
    assign stat.out_free = !out_valid_reg || m_ready;

    // scan: a load sets the start; a step advances a clear, extends the run or moves the window
    always_comb begin
        start_next = start_reg;
        pos_next   = pos_reg;
        run_next   = run_reg;
        if (cmd.load_req) begin
            start_next = STW'(ffv_reg);
            run_next   = 8'd0;
            // read port starts at the search floor, entry zero or the vector
            if (s_req.mode == MODE_RANGE) begin
                pos_next = STW'(ffv_reg);
            end else if (s_req.mode == MODE_CLEAR) begin
                pos_next = '0;
            end else begin
                pos_next = STW'(s_req.vector);
            end
        end else if (cmd.step) begin
            if (req_reg.mode == MODE_CLEAR) begin
                // clearing pass: one map entry per cycle
                pos_next = pos_reg + STW'(1);
            end else if (bit_here) begin
                // a short stretch: later starts inside it cannot do better
                if (req_reg.aligned) begin
                    start_next = STW'(win_end);
                    pos_next   = STW'(win_end);
                end else begin
                    start_next = pos_reg + STW'(1);
                    pos_next   = pos_reg + STW'(1);
                end
                run_next = 8'd0;
            end else begin
                pos_next = pos_reg + STW'(1);
                run_next = run_reg + 8'd1;
            end
        end
    end

    // result of the current request
    always_comb begin
        rsp_next = '0;
        unique case (req_reg.mode)
            MODE_REGISTER: begin
                if (refused) begin
                    rsp_next.status = 1'b1;
                end else begin
                    rsp_next.descriptor_low = {req_reg.handler_address[31:16], 1'b1, dpl,
                                               1'b0, gate_type, 8'h00, sel_reg,
                                               req_reg.handler_address[15:0]};
                    rsp_next.descriptor_high = req_reg.handler_address[63:32];
                end
            end
            MODE_RANGE: begin
                if (!no_fit) begin
                    rsp_next.range_start = start_reg[7:0];
                    rsp_next.range_len   = run_reg;
                end
            end
            MODE_CLEAR: rsp_next = '0;
            MODE_QUERY: rsp_next.vector_used = vec_ok && vec_bit;
            default:    rsp_next = '0;
        endcase
    end

    // request and scan registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // reset starts a clearing pass from entry zero
            req_reg.mode <= MODE_CLEAR;
        end else if (cmd.load_req) begin
            req_reg <= s_req;
        end
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
        start_reg <= start_next;
        run_reg   <= run_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= CODE_SELECTOR_RESET;
            ffv_reg <= FIRST_FREE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CODE_SELECTOR: sel_reg <= cfg_data;
                CFG_FIRST_FREE:    ffv_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // taken/free map writes: zero during a clearing pass, one on registration
    assign map_we    = (cmd.step && req_reg.mode == MODE_CLEAR)
                    || (cmd.commit && req_reg.mode == MODE_REGISTER && !refused);
    assign map_wdata = (req_reg.mode == MODE_REGISTER);

    // taken/free map, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[pos_reg[IW-1:0]] <= map_wdata;
        end
        map_rd_reg <= map_mem[pos_next[IW-1:0]];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.commit) begin
            out_reg <= rsp_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_rsp   = out_reg;

endmodule

// ===== hw/rtl/interrupt_vector_allocator.sv =====
// Interrupt vector allocator.
// Input channel s_valid/s_ready/s_req carries one request: register a handler
// (returns its gate descriptor and marks the vector taken), search for a run
// of free vectors, clear the map, or query one vector. Result channel
// m_valid/m_ready/m_rsp returns exactly one response per request.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the code
// selector (index 0) and the lowest search start (index 1); always ready. The
// user must write it only while no request is outstanding; it is not enforced.
// The map is a one-bit memory with one write and one registered read port.
// Register and query results need no scan; they commit once the output is free.
// A range search steps one map bit per cycle and a clear writes one entry per
// cycle. One request is worked on at a time, and a new one is taken from the
// cycle after the previous result enters the output register.
// Reset loads selector 8 and start 32 and runs a clearing pass over the map;
// s_ready rises once the clearing pass has finished.
// When the receiver stalls, a finished result waits in the controller's work
// state until the output register frees; nothing is dropped.
module interrupt_vector_allocator #(
    parameter int VECTOR_COUNT = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  iva_pkg::iva_req_t s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output iva_pkg::iva_rsp_t m_rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import iva_pkg::*;

    iva_cmd_t  cmd;
    iva_stat_t stat;

    assign cfg_ready = 1'b1;

    iva_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    iva_datapath #(
        .VECTOR_COUNT (VECTOR_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_req     (s_req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_rsp     (m_rsp)
    );

`ifndef NO_ASSERTIONS
    // one request at a time: acceptance closes the input side
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // a new response only ever ends a busy period
    a_rsp_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("response appeared without a request in work");

    // a refused registration carries no descriptor
    a_refused_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.status |-> m_rsp.descriptor_low == 64'd0
                                    && m_rsp.descriptor_high == 32'd0)
        else $error("refused registration with descriptor");
`endif

endmodule
